// ===== hw/rtl/owbm_pkg.sv =====
// ----------------------------------------------------------------------------
// owbm_pkg: shared types and constants for the single-wire bus master
// Phase codes, item kinds, register indexes, reset values and the structs
// passed between the register bank, the sequencer and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package owbm_pkg;

   localparam int unsigned LongWidth  = 10;
   localparam int unsigned StartWidth = 4;
   localparam int unsigned SlotWidth  = 8;
   localparam int unsigned CsrIdxWidth  = 3;
   localparam int unsigned CsrDataWidth = 10;

   typedef enum logic [1:0] {
      KIND_TICK  = 2'd0,
      KIND_RESET = 2'd1,
      KIND_BYTE  = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      PH_IDLE       = 3'd0,
      PH_RST_LOW    = 3'd1,
      PH_RST_WAIT   = 3'd2,
      PH_RST_RECOV  = 3'd3,
      PH_SLOT_START = 3'd4,
      PH_SLOT_DRIVE = 3'd5,
      PH_SLOT_TAIL  = 3'd6
   } phase_type;

   localparam logic [CsrIdxWidth-1:0] REG_RESET_LOW    = 3'd0;
   localparam logic [CsrIdxWidth-1:0] REG_PRESENCE_WAIT = 3'd1;
   localparam logic [CsrIdxWidth-1:0] REG_RESET_RECOV  = 3'd2;
   localparam logic [CsrIdxWidth-1:0] REG_START_PULSE  = 3'd3;
   localparam logic [CsrIdxWidth-1:0] REG_SAMPLE_DELAY = 3'd4;
   localparam logic [CsrIdxWidth-1:0] REG_SLOT_TAIL    = 3'd5;

   localparam logic [LongWidth-1:0]  RESET_LOW_DEFAULT     = 10'd500;
   localparam logic [LongWidth-1:0]  PRESENCE_WAIT_DEFAULT = 10'd70;
   localparam logic [LongWidth-1:0]  RESET_RECOV_DEFAULT   = 10'd320;
   localparam logic [StartWidth-1:0] START_PULSE_DEFAULT   = 4'd1;
   localparam logic [SlotWidth-1:0]  SAMPLE_DELAY_DEFAULT  = 8'd11;
   localparam logic [SlotWidth-1:0]  SLOT_TAIL_DEFAULT     = 8'd55;

   typedef struct packed {
      logic [LongWidth-1:0]  reset_low_ticks;
      logic [LongWidth-1:0]  presence_wait_ticks;
      logic [LongWidth-1:0]  reset_recovery_ticks;
      logic [StartWidth-1:0] start_pulse_ticks;
      logic [SlotWidth-1:0]  sample_delay_ticks;
      logic [SlotWidth-1:0]  slot_tail_ticks;
   } cfg_type;

   typedef struct packed {
      logic       line_drive;
      logic       busy_res;
      logic       done_res;
      logic       presence;
      logic [7:0] rx_byte;
   } result_type;

endpackage : owbm_pkg

`default_nettype wire

// ===== hw/rtl/owbm_csr.sv =====
// ----------------------------------------------------------------------------
// owbm_csr: timing register bank
// Holds the six bus timing registers, written through the plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module owbm_csr
   import owbm_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_wr_en,
   input  wire logic [CsrIdxWidth-1:0]  csr_index,
   input  wire logic [CsrDataWidth-1:0] csr_wdata,
   output cfg_type                      cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_RESET_LOW:     cfg_in.reset_low_ticks      = csr_wdata;
            REG_PRESENCE_WAIT: cfg_in.presence_wait_ticks  = csr_wdata;
            REG_RESET_RECOV:   cfg_in.reset_recovery_ticks = csr_wdata;
            REG_START_PULSE:   cfg_in.start_pulse_ticks    = csr_wdata[StartWidth-1:0];
            REG_SAMPLE_DELAY:  cfg_in.sample_delay_ticks   = csr_wdata[SlotWidth-1:0];
            REG_SLOT_TAIL:     cfg_in.slot_tail_ticks      = csr_wdata[SlotWidth-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low_ticks      <= RESET_LOW_DEFAULT;
         cfg_ff.presence_wait_ticks  <= PRESENCE_WAIT_DEFAULT;
         cfg_ff.reset_recovery_ticks <= RESET_RECOV_DEFAULT;
         cfg_ff.start_pulse_ticks    <= START_PULSE_DEFAULT;
         cfg_ff.sample_delay_ticks   <= SAMPLE_DELAY_DEFAULT;
         cfg_ff.slot_tail_ticks      <= SLOT_TAIL_DEFAULT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule : owbm_csr

`default_nettype wire

// ===== hw/rtl/owbm_seq.sv =====
// ----------------------------------------------------------------------------
// owbm_seq: bus sequencer
// Phase register, tick counter, bit index and shift register; one step per
// accepted item, with the result of that step formed combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module owbm_seq
   import owbm_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step_en,
   input  wire logic [1:0] req_kind,
   input  wire logic [7:0] req_tx_byte,
   input  wire logic       req_line_in,
   input  wire cfg_type    cfg,
   output result_type      res
);

   phase_type phase_ff, phase_in;
   logic [LongWidth-1:0] count_ff, count_in;
   logic [2:0] bit_ff, bit_in;
   logic [7:0] shift_ff, shift_in;
   logic       pres_ff, pres_in;
   logic       drv_ff, drv_in;

   logic [LongWidth-1:0] cnt_inc;
   logic [LongWidth-1:0] lim_low, lim_wait, lim_start, lim_sample, lim_tail;
   logic                 slot_end;
   logic                 done;

   // zero in reset low, presence wait, start pulse and sample delay counts as one tick
   assign lim_low    = (cfg.reset_low_ticks == '0) ? 10'd1 : cfg.reset_low_ticks;
   assign lim_wait   = (cfg.presence_wait_ticks == '0) ? 10'd1 : cfg.presence_wait_ticks;
   assign lim_start  = (cfg.start_pulse_ticks == '0) ? 10'd1
                       : {6'd0, cfg.start_pulse_ticks};
   assign lim_sample = (cfg.sample_delay_ticks == '0) ? 10'd1
                       : {2'd0, cfg.sample_delay_ticks};
   assign lim_tail   = {2'd0, cfg.slot_tail_ticks};
   assign cnt_inc    = count_ff + 10'd1;

   // next state
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      pres_in  = pres_ff;
      drv_in   = drv_ff;
      slot_end = 1'b0;
      done     = 1'b0;
      if (phase_ff == PH_IDLE) begin
         case (req_kind)
            KIND_RESET: begin
               phase_in = PH_RST_LOW;
               count_in = '0;
            end
            KIND_BYTE: begin
               phase_in = PH_SLOT_START;
               count_in = '0;
               bit_in   = '0;
               shift_in = req_tx_byte;
               drv_in   = 1'b1;
            end
            default: ;
         endcase
      end else if (req_kind == KIND_TICK) begin
         count_in = cnt_inc;
         unique case (phase_ff)
            PH_RST_LOW: begin
               if (cnt_inc >= lim_low) begin
                  phase_in = PH_RST_WAIT;
                  count_in = '0;
               end
            end
            PH_RST_WAIT: begin
               if (cnt_inc >= lim_wait) begin
                  pres_in  = ~req_line_in;
                  count_in = '0;
                  if (cfg.reset_recovery_ticks == '0) begin
                     phase_in = PH_IDLE;
                     done     = 1'b1;
                  end else begin
                     phase_in = PH_RST_RECOV;
                  end
               end
            end
            PH_RST_RECOV: begin
               if (cnt_inc >= cfg.reset_recovery_ticks) begin
                  phase_in = PH_IDLE;
                  count_in = '0;
                  done     = 1'b1;
               end
            end
            PH_SLOT_START: begin
               if (cnt_inc >= lim_start) begin
                  drv_in   = shift_ff[0];
                  phase_in = PH_SLOT_DRIVE;
                  count_in = '0;
               end
            end
            PH_SLOT_DRIVE: begin
               if (cnt_inc >= lim_sample) begin
                  shift_in = {req_line_in, shift_ff[7:1]};
                  count_in = '0;
                  if (cfg.slot_tail_ticks == '0) begin
                     slot_end = 1'b1;
                  end else begin
                     phase_in = PH_SLOT_TAIL;
                  end
               end
            end
            PH_SLOT_TAIL: begin
               if (cnt_inc >= lim_tail) begin
                  slot_end = 1'b1;
               end
            end
            default: ;
         endcase
         if (slot_end) begin
            drv_in   = 1'b1;
            count_in = '0;
            if (bit_ff == 3'd7) begin
               bit_in   = '0;
               phase_in = PH_IDLE;
               done     = 1'b1;
            end else begin
               bit_in   = bit_ff + 3'd1;
               phase_in = PH_SLOT_START;
            end
         end
      end
   end

   // result shows the state after this item
   always_comb begin
      res.busy_res = (phase_in != PH_IDLE);
      res.done_res = done;
      res.presence = pres_in;
      res.rx_byte  = shift_in;
      unique case (phase_in)
         PH_RST_LOW, PH_SLOT_START:   res.line_drive = 1'b0;
         PH_SLOT_DRIVE, PH_SLOT_TAIL: res.line_drive = drv_in;
         default:                     res.line_drive = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         count_ff <= '0;
         bit_ff   <= '0;
         shift_ff <= '0;
         pres_ff  <= 1'b0;
         drv_ff   <= 1'b1;
      end else if (step_en) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         pres_ff  <= pres_in;
         drv_ff   <= drv_in;
      end
   end

endmodule : owbm_seq

`default_nettype wire

// ===== hw/rtl/one_wire_bus_master_unit.sv =====
// result: registered, valid in the cycle after the input transfer
// throughput: one item per cycle while rsp_ready is high; the result register frees in the same cycle it is taken
// every input item gives exactly one result item
// reset: synchronous, active high; clears the sequencer to idle, presence to 0 and
// loads the timing registers with their defaults
// ----------------------------------------------------------------------------
// one_wire_bus_master_unit: single-wire bus master top level
// Timing register bank, bus sequencer and the result register with handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module one_wire_bus_master_unit
   import owbm_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output      logic                    req_ready,
   input  wire logic [1:0]              req_kind,
   input  wire logic [7:0]              req_tx_byte,
   input  wire logic                    req_line_in,
   output      logic                    rsp_valid,
   input  wire logic                    rsp_ready,
   output      logic                    rsp_line_drive,
   output      logic                    rsp_busy_res,
   output      logic                    rsp_done_res,
   output      logic                    rsp_presence,
   output      logic [7:0]              rsp_rx_byte,
   input  wire logic                    csr_wr_en,
   input  wire logic [CsrIdxWidth-1:0]  csr_index,
   input  wire logic [CsrDataWidth-1:0] csr_wdata
);

   cfg_type    cfg;
   result_type step_res;
   result_type res_ff;
   logic       rsp_valid_ff;
   logic       accept;

   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign accept    = req_valid & req_ready;

   owbm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   owbm_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .step_en     (accept),
      .req_kind    (req_kind),
      .req_tx_byte (req_tx_byte),
      .req_line_in (req_line_in),
      .cfg         (cfg),
      .res         (step_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         res_ff <= step_res;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_line_drive = res_ff.line_drive;
   assign rsp_busy_res   = res_ff.busy_res;
   assign rsp_done_res   = res_ff.done_res;
   assign rsp_presence   = res_ff.presence;
   assign rsp_rx_byte    = res_ff.rx_byte;

`ifndef NO_ASSERTIONS
   // a completed command leaves the block idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && res_ff.done_res |-> !res_ff.busy_res)
      else $error("done result while still busy");

   // the bus is only pulled low during a command
   a_low_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !res_ff.line_drive |-> res_ff.busy_res)
      else $error("line pulled low while idle");

   // result register is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("result valid right after reset");

   // a transfer always loads the result register
   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted item produced no result");
`endif

endmodule : one_wire_bus_master_unit

`default_nettype wire
